// ===== rtl/ctsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Context tree symbol counter: shared package
// Widths, codes, state encoding and elaboration-time helpers used by the
// context tree symbol counter and its submodules.
// ----------------------------------------------------------------------------
package ctsc_pkg;

	localparam int MAX_ALPHABET_DEF = 4;
	localparam int MAX_DEPTH_DEF    = 6;
	localparam int COUNT_WIDTH_DEF  = 32;

	localparam int ALPHA_RESET = 4;
	localparam int DEPTH_RESET = 6;

	localparam int ACTION_W  = 2;
	localparam int VALUE_W   = 32;
	localparam int APB_DW    = 32;
	localparam int PADDR_W   = 3;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_ALPHABET = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_DEPTH    = REG_IDX_W'(1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_RESTART = 2'd1,
		ACT_PUSH    = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_READ
	} state_t;

	typedef struct packed {
		logic rd;
		logic bump;
		logic clr;
	} bank_ctl_t;

	function automatic longint unsigned node_total(input int unsigned m, input int unsigned h);
		longint unsigned total;
		longint unsigned level;
		total = 1;
		level = 1;
		for (int unsigned d = 0; d < h; d++) begin
			level = level * m;
			total = total + level;
		end
		return total;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ctsc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Context tree symbol counter: history cell
// Holds one history symbol and forwards the tree path node of its depth to
// the next cell, one cell per cycle.
// ----------------------------------------------------------------------------
module ctsc_cell #(
	parameter int NODE_W = 13,
	parameter int SYM_W  = 2,
	parameter int M_W    = 3
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire logic [M_W-1:0]    m,
	input  wire logic [SYM_W-1:0]  prev_sym,
	input  wire logic              prev_valid,
	input  wire logic [NODE_W-1:0] prev_node,
	output logic      [SYM_W-1:0]  sym,
	output logic                   valid,
	output logic      [NODE_W-1:0] node
);

	localparam int PW = NODE_W + M_W;

	logic [SYM_W-1:0]  hist_q;
	logic              valid_q;
	logic [NODE_W-1:0] node_q;
	logic [PW-1:0]     prod;
	logic [PW-1:0]     child;

	assign prod  = PW'(prev_node) * PW'(m);
	assign child = prod + PW'(hist_q) + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (shift) begin
				hist_q <= prev_sym;
			end
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prev_valid) begin
			node_q <= child[NODE_W-1:0];
		end
	end

	assign sym   = hist_q;
	assign valid = valid_q;
	assign node  = node_q;

endmodule
`default_nettype wire

// ===== rtl/ctsc_count_bank.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Context tree symbol counter: count bank
// Count memory with registered read, saturating read-modify-write bump in the
// cycle after the read, and a clear write port for the sweep.
// ----------------------------------------------------------------------------
module ctsc_count_bank #(
	parameter int SLOTS       = 21844,
	parameter int ADDR_W      = 15,
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ctsc_pkg::bank_ctl_t    ctl,
	input  wire logic [ADDR_W-1:0]      addr,
	output logic      [COUNT_WIDTH-1:0] rd_data
);

	import ctsc_pkg::*;

	logic [COUNT_WIDTH-1:0] mem [SLOTS];
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic                   bump_s1;
	logic [ADDR_W-1:0]      addr_s1;
	logic [COUNT_WIDTH-1:0] bump_val;

	assign bump_val = (&rd_data_q) ? rd_data_q : rd_data_q + COUNT_WIDTH'(1);

	always_ff @(posedge clk) begin
		if (ctl.rd) begin
			rd_data_q <= mem[addr];
		end
		if (ctl.clr) begin
			mem[addr] <= '0;
		end else if (bump_s1) begin
			mem[addr_s1] <= bump_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bump_s1 <= 1'b0;
		end else begin
			bump_s1 <= ctl.bump;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/context_tree_symbol_counter_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Context tree symbol counter
// Per-context symbol counts over a heap-ordered m-ary context tree. A row of
// history cells spells the tree path of each pushed symbol; a count bank with
// one read and one write port is bumped once per node along that path.
//
//   channel   signals                                    direction
//   config    psel penable pwrite paddr pwdata prdata     in / prdata out
//   item      item_valid item_ready action symbol node    in (ready out)
//   result    result_valid result_ready value counted err out (ready in)
//
// A push with full history accesses the count bank once per tree level
// (h = context depth) plus root, then does the last write-back. A read goes
// through the read state; clear, new sequence, bad or short push answer from idle.
// Reset and the clear action sweep all node_total(MAX_ALPHABET, MAX_DEPTH) *
// MAX_ALPHABET entries (21844 by default) of the count bank, one entry a cycle;
// no request is taken meanwhile. A stalled result holds the next request off.
// ----------------------------------------------------------------------------
module context_tree_symbol_counter_unit #(
	parameter int MAX_ALPHABET = ctsc_pkg::MAX_ALPHABET_DEF,
	parameter int MAX_DEPTH    = ctsc_pkg::MAX_DEPTH_DEF,
	parameter int COUNT_WIDTH  = ctsc_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [ctsc_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [ctsc_pkg::APB_DW-1:0]          pwdata,
	output logic      [ctsc_pkg::APB_DW-1:0]          prdata,
	output logic                                      pready,
	input  wire logic                                 item_valid,
	output logic                                      item_ready,
	input  wire logic [ctsc_pkg::ACTION_W-1:0]        action,
	input  wire logic [$clog2(MAX_ALPHABET)-1:0]      symbol,
	input  wire logic [$clog2(ctsc_pkg::node_total(MAX_ALPHABET, MAX_DEPTH))-1:0] node_index,
	output logic                                      result_valid,
	input  wire logic                                 result_ready,
	output logic      [ctsc_pkg::VALUE_W-1:0]         value,
	output logic                                      counted,
	output logic                                      error
);

	import ctsc_pkg::*;

	localparam longint unsigned TREE_NODES  = node_total(MAX_ALPHABET, MAX_DEPTH);
	localparam longint unsigned TABLE_SLOTS = TREE_NODES * MAX_ALPHABET;
	localparam int NODE_W   = $clog2(TREE_NODES);
	localparam int ADDR_W   = $clog2(TABLE_SLOTS);
	localparam int SYM_W    = $clog2(MAX_ALPHABET);
	localparam int CFG_A_W  = $clog2(MAX_ALPHABET + 1);
	localparam int CFG_D_W  = $clog2(MAX_DEPTH + 1);
	localparam int ALPHA_RV = (ALPHA_RESET < MAX_ALPHABET) ? ALPHA_RESET : MAX_ALPHABET;
	localparam int DEPTH_RV = (DEPTH_RESET < MAX_DEPTH) ? DEPTH_RESET : MAX_DEPTH;
	localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_SLOTS - 1);
	localparam logic [ADDR_W-1:0] ALPHA_MUL = ADDR_W'(MAX_ALPHABET);

	function automatic logic [ADDR_W-1:0] slot_of(input logic [NODE_W-1:0] n,
	                                             input logic [SYM_W-1:0] s);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(n) * ALPHA_MUL;
		return base + ADDR_W'(s);
	endfunction

	state_t                 state_q, state_d;
	logic [CFG_A_W-1:0]     alpha_q;
	logic [CFG_D_W-1:0]     depth_q;
	logic [CFG_A_W-1:0]     m_eff;
	logic [CFG_D_W-1:0]     h_eff;
	logic [CFG_D_W-1:0]     fill_q, fill_d;
	logic [CFG_D_W-1:0]     walk_left_q, left_d;
	logic [ADDR_W-1:0]      clr_addr_q, clr_addr_d;
	logic [VALUE_W-1:0]     total_q, total_d, total_inc;
	logic [SYM_W-1:0]       sym_q, sym_d;
	logic                   rd_err_q, rd_err_d;
	logic                   res_valid_q;
	logic [VALUE_W-1:0]     value_q, res_value_d;
	logic                   counted_q, res_counted_d;
	logic                   error_q, res_error_d;
	logic                   load_res;
	logic                   ready_c;
	logic                   walk_start;
	logic                   hist_shift;
	logic [SYM_W-1:0]       shift_sym;
	logic                   sym_bad;
	logic                   node_bad;
	logic                   cfg_we;
	logic [REG_IDX_W-1:0]   reg_idx;
	bank_ctl_t              bank_ctl;
	logic [ADDR_W-1:0]      bank_addr;
	logic [COUNT_WIDTH-1:0] rd_data;
	logic [NODE_W:0]        limit_tab [MAX_ALPHABET+1][MAX_DEPTH+1];
	logic [NODE_W-1:0]      walk_node;

	logic [MAX_DEPTH-1:0]   tok_v;
	logic [MAX_DEPTH-1:0]   prev_v;
	logic [NODE_W-1:0]      tok_node  [MAX_DEPTH];
	logic [NODE_W-1:0]      prev_node [MAX_DEPTH];
	logic [SYM_W-1:0]       cell_sym  [MAX_DEPTH];
	logic [SYM_W-1:0]       prev_sym  [MAX_DEPTH];

	// configuration port
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_comb begin
		unique case (reg_idx)
			REG_ALPHABET: prdata = APB_DW'(alpha_q);
			REG_DEPTH:    prdata = APB_DW'(depth_q);
		endcase
	end

	assign m_eff = (alpha_q < CFG_A_W'(2)) ? CFG_A_W'(2) :
	               (alpha_q > CFG_A_W'(MAX_ALPHABET)) ? CFG_A_W'(MAX_ALPHABET) : alpha_q;
	assign h_eff = (depth_q > CFG_D_W'(MAX_DEPTH)) ? CFG_D_W'(MAX_DEPTH) : depth_q;

	for (genvar gm = 0; gm <= MAX_ALPHABET; gm++) begin : g_lim_m
		for (genvar gh = 0; gh <= MAX_DEPTH; gh++) begin : g_lim_h
			assign limit_tab[gm][gh] = (NODE_W+1)'(node_total(gm, gh));
		end
	end

	assign sym_bad   = {1'b0, symbol} >= (SYM_W+1)'(m_eff);
	assign node_bad  = {1'b0, node_index} >= limit_tab[m_eff][h_eff];
	assign total_inc = (&total_q) ? total_q : total_q + VALUE_W'(1);

	// history cells
	for (genvar d = 0; d < MAX_DEPTH; d++) begin : g_cell
		if (d == 0) begin : g_head
			assign prev_v[d]    = walk_start && (h_eff != '0);
			assign prev_node[d] = '0;
			assign prev_sym[d]  = shift_sym;
		end else begin : g_body
			assign prev_v[d]    = tok_v[d-1] && (CFG_D_W'(d) < h_eff);
			assign prev_node[d] = tok_node[d-1];
			assign prev_sym[d]  = cell_sym[d-1];
		end

		ctsc_cell #(
			.NODE_W (NODE_W),
			.SYM_W  (SYM_W),
			.M_W    (CFG_A_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (hist_shift),
			.m          (m_eff),
			.prev_sym   (prev_sym[d]),
			.prev_valid (prev_v[d]),
			.prev_node  (prev_node[d]),
			.sym        (cell_sym[d]),
			.valid      (tok_v[d]),
			.node       (tok_node[d])
		);
	end

	always_comb begin
		walk_node = '0;
		for (int d = 0; d < MAX_DEPTH; d++) begin
			if (tok_v[d]) begin
				walk_node = walk_node | tok_node[d];
			end
		end
	end

	ctsc_count_bank #(
		.SLOTS       (int'(TABLE_SLOTS)),
		.ADDR_W      (ADDR_W),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (bank_ctl),
		.addr    (bank_addr),
		.rd_data (rd_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		left_d        = walk_left_q;
		clr_addr_d    = clr_addr_q;
		fill_d        = fill_q;
		total_d       = total_q;
		sym_d         = sym_q;
		rd_err_d      = rd_err_q;
		load_res      = 1'b0;
		res_value_d   = total_q;
		res_counted_d = 1'b0;
		res_error_d   = 1'b0;
		bank_ctl      = '0;
		bank_addr     = slot_of('0, symbol);
		ready_c       = 1'b0;
		walk_start    = 1'b0;
		hist_shift    = 1'b0;
		shift_sym     = symbol;
		unique case (state_q)
			ST_CLEAR: begin
				bank_ctl.clr = 1'b1;
				bank_addr    = clr_addr_q;
				clr_addr_d   = clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == LAST_SLOT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				ready_c = !res_valid_q || result_ready;
				if (item_valid && ready_c) begin
					unique case (action_t'(action))
						ACT_CLEAR: begin
							total_d     = '0;
							fill_d      = '0;
							clr_addr_d  = '0;
							state_d     = ST_CLEAR;
							load_res    = 1'b1;
							res_value_d = '0;
						end
						ACT_RESTART: begin
							fill_d   = '0;
							load_res = 1'b1;
						end
						ACT_PUSH: begin
							if (sym_bad) begin
								load_res    = 1'b1;
								res_error_d = 1'b1;
							end else if (fill_q >= h_eff) begin
								walk_start    = 1'b1;
								bank_ctl.rd   = 1'b1;
								bank_ctl.bump = 1'b1;
								bank_addr     = slot_of('0, symbol);
								left_d        = h_eff;
								sym_d         = symbol;
								state_d       = ST_WALK;
							end else begin
								hist_shift = 1'b1;
								fill_d     = fill_q + CFG_D_W'(1);
								load_res   = 1'b1;
							end
						end
						ACT_READ: begin
							bank_ctl.rd = 1'b1;
							bank_addr   = slot_of(node_index, symbol);
							rd_err_d    = sym_bad || node_bad;
							state_d     = ST_READ;
						end
					endcase
				end
			end
			ST_WALK: begin
				if (walk_left_q != '0) begin
					bank_ctl.rd   = 1'b1;
					bank_ctl.bump = 1'b1;
					bank_addr     = slot_of(walk_node, sym_q);
					left_d        = walk_left_q - CFG_D_W'(1);
				end else begin
					hist_shift    = 1'b1;
					shift_sym     = sym_q;
					total_d       = total_inc;
					load_res      = 1'b1;
					res_value_d   = total_inc;
					res_counted_d = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_READ: begin
				load_res    = 1'b1;
				res_value_d = rd_err_q ? '0 : VALUE_W'(rd_data);
				res_error_d = rd_err_q;
				state_d     = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q     <= CFG_A_W'(ALPHA_RV);
			depth_q     <= CFG_D_W'(DEPTH_RV);
			fill_q      <= '0;
			walk_left_q <= '0;
			clr_addr_q  <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we && reg_idx == REG_ALPHABET) begin
				alpha_q <= pwdata[CFG_A_W-1:0];
			end
			if (cfg_we && reg_idx == REG_DEPTH) begin
				depth_q <= pwdata[CFG_D_W-1:0];
			end
			if (cfg_we) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_d;
			end
			walk_left_q <= left_d;
			clr_addr_q  <= clr_addr_d;
			total_q     <= total_d;
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sym_q    <= sym_d;
		rd_err_q <= rd_err_d;
		if (load_res) begin
			value_q   <= res_value_d;
			counted_q <= res_counted_d;
			error_q   <= res_error_d;
		end
	end

	assign item_ready   = ready_c;
	assign result_valid = res_valid_q;
	assign value        = value_q;
	assign counted      = counted_q;
	assign error        = error_q;

`ifndef NO_ASSERTIONS
	a_tok_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v))
		else $error("more than one path token in the cell row");

	a_walk_token: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && walk_left_q != '0) |-> $onehot(tok_v))
		else $error("walk step without a path token");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= h_eff)
		else $error("history fill beyond context depth");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (result_valid || state_q != ST_IDLE))
		else $error("request accepted without progress");
`endif

endmodule
`default_nettype wire

// ===== dv/context_tree_symbol_counter_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Context tree symbol counter: result checker
// Watches the register port and the request and result channels, keeps its own copy of
// the per-node symbol counts, the symbol history and the position total, and
// compares every result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module context_tree_symbol_counter_checker #(
	parameter int SYM_W  = 2,
	parameter int NODE_W = 13
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [ctsc_pkg::PADDR_W-1:0]  paddr,
	input  logic [ctsc_pkg::APB_DW-1:0]   pwdata,
	input  logic                          item_valid,
	input  logic                          item_ready,
	input  logic [ctsc_pkg::ACTION_W-1:0] action,
	input  logic [SYM_W-1:0]              symbol,
	input  logic [NODE_W-1:0]             node_index,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  logic [ctsc_pkg::VALUE_W-1:0]  value,
	input  logic                          counted,
	input  logic                          error,
	output int                            mismatches,
	output int                            outstanding,
	output int                            checked
);

	import ctsc_pkg::*;

	localparam int TREE_NODES =
		(MAX_ALPHABET_DEF ** (MAX_DEPTH_DEF + 1) - 1) / (MAX_ALPHABET_DEF - 1);

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               counted;
		logic               error;
	} outcome_t;

	logic [COUNT_WIDTH_DEF-1:0] tally [TREE_NODES][MAX_ALPHABET_DEF];
	logic [SYM_W-1:0]           recent [MAX_DEPTH_DEF];
	int unsigned                fill;
	logic [VALUE_W-1:0]         positions;
	logic [2:0]                 alpha_reg;
	logic [2:0]                 depth_reg;
	outcome_t                   predicted_q[$];
	int                         errs;
	int                         seen;

	function automatic int unsigned eff_alpha();
		if (alpha_reg < 2) return 2;
		if (alpha_reg > MAX_ALPHABET_DEF) return MAX_ALPHABET_DEF;
		return alpha_reg;
	endfunction

	function automatic int unsigned eff_depth();
		if (depth_reg > MAX_DEPTH_DEF) return MAX_DEPTH_DEF;
		return depth_reg;
	endfunction

	function automatic void wipe_counts();
		for (int i = 0; i < TREE_NODES; i++)
			for (int j = 0; j < MAX_ALPHABET_DEF; j++)
				tally[i][j] = '0;
	endfunction

	function automatic void bump_count(int unsigned node, logic [SYM_W-1:0] sym);
		if (tally[node][sym] != '1) tally[node][sym] = tally[node][sym] + 1'b1;
	endfunction

	function automatic outcome_t advance_tree(action_t act, logic [SYM_W-1:0] sym,
			logic [NODE_W-1:0] node);
		outcome_t    o;
		int unsigned m;
		int unsigned h;
		int unsigned p;
		o = '0;
		m = eff_alpha();
		h = eff_depth();
		case (act)
			ACT_CLEAR: begin
				wipe_counts();
				positions = '0;
				fill = 0;
				o.value = positions;
			end
			ACT_RESTART: begin
				fill = 0;
				o.value = positions;
			end
			ACT_PUSH: begin
				if (sym >= m) begin
					o.error = 1'b1;
				end else begin
					if (fill >= h) begin
						p = 0;
						bump_count(p, sym);
						for (int unsigned d = 0; d < h; d++) begin
							p = p * m + 1 + recent[d];
							bump_count(p, sym);
						end
						if (positions != '1) positions = positions + 1'b1;
						o.counted = 1'b1;
					end
					for (int d = MAX_DEPTH_DEF - 1; d > 0; d--)
						recent[d] = recent[d-1];
					recent[0] = sym;
					if (fill < h) fill++;
				end
				o.value = positions;
			end
			default: begin
				if (sym >= m || node >= (m ** (h + 1) - 1) / (m - 1))
					o.error = 1'b1;
				else
					o.value = tally[node][sym];
			end
		endcase
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t got;
		outcome_t want;
		outcome_t fresh;
		if (!arst_n) begin
			wipe_counts();
			for (int d = 0; d < MAX_DEPTH_DEF; d++)
				recent[d] = '0;
			fill = 0;
			positions = '0;
			alpha_reg = 3'(ALPHA_RESET);
			depth_reg = 3'(DEPTH_RESET);
			predicted_q.delete();
			errs = 0;
			seen = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[PADDR_W-1:2])
					REG_ALPHABET: begin
						alpha_reg = pwdata[2:0];
						fill = 0;
					end
					REG_DEPTH: begin
						depth_reg = pwdata[2:0];
						fill = 0;
					end
					default: ;
				endcase
			end
			if (item_valid && item_ready) begin
				fresh = advance_tree(action_t'(action), symbol, node_index);
				predicted_q = {predicted_q, fresh};
			end
			if (result_valid && result_ready) begin
				got = {value, counted, error};
				if (predicted_q.size() == 0) begin
					errs++;
					$display("%0t: unexpected result expected none actual value %0d counted %0b error %0b",
						$time, got.value, got.counted, got.error);
				end else begin
					want = predicted_q.pop_front();
					seen++;
					if (got.value !== want.value) begin
						errs++;
						$display("%0t: value expected %0d actual %0d",
							$time, want.value, got.value);
					end
					if (got.counted !== want.counted) begin
						errs++;
						$display("%0t: counted expected %0b actual %0b",
							$time, want.counted, got.counted);
					end
					if (got.error !== want.error) begin
						errs++;
						$display("%0t: error expected %0b actual %0b",
							$time, want.error, got.error);
					end
				end
			end
		end
		mismatches  <= errs;
		outstanding <= predicted_q.size();
		checked     <= seen;
	end

endmodule

// ===== dv/context_tree_symbol_counter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Context tree symbol counter: testbench top
// Drives a short directed run and then random request streams under a range
// of alphabet size and depth settings, with random gaps on both channels outside
// one calm phase. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module context_tree_symbol_counter_unit_tb;
	import ctsc_pkg::*;

	localparam int SYM_W          = $clog2(MAX_ALPHABET_DEF);
	localparam int NODE_W         = $clog2(node_total(MAX_ALPHABET_DEF, MAX_DEPTH_DEF));
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int PHASE_ITEMS    = 140;
	localparam int PHASES         = 10;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [PADDR_W-1:0]  paddr        = '0;
	logic [APB_DW-1:0]   pwdata       = '0;
	wire  [APB_DW-1:0]   prdata;
	wire                 pready;
	logic                item_valid   = 1'b0;
	wire                 item_ready;
	logic [ACTION_W-1:0] action       = '0;
	logic [SYM_W-1:0]    symbol       = '0;
	logic [NODE_W-1:0]   node_index   = '0;
	wire                 result_valid;
	logic                result_ready = 1'b0;
	wire  [VALUE_W-1:0]  value;
	wire                 counted;
	wire                 error;

	logic                calm         = 1'b0;
	int                  idle_cycles  = 0;
	int                  mismatches;
	int                  outstanding;
	int                  checked;
	int                  sent         = 0;
	int                  clears       = 0;
	int                  settings     = 0;
	int unsigned         m_use        = ALPHA_RESET;
	int unsigned         h_use        = DEPTH_RESET;

	logic [2:0] alpha_plan [PHASES] = '{3'd2, 3'd3, 3'd0, 3'd7, 3'd4,
		3'd1, 3'd5, 3'd3, 3'd4, 3'd2};
	logic [2:0] depth_plan [PHASES] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd7,
		3'd4, 3'd5, 3'd6, 3'd6, 3'd6};

	context_tree_symbol_counter_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.symbol       (symbol),
		.node_index   (node_index),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.counted      (counted),
		.error        (error)
	);

	context_tree_symbol_counter_checker #(
		.SYM_W  (SYM_W),
		.NODE_W (NODE_W)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.symbol       (symbol),
		.node_index   (node_index),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.value        (value),
		.counted      (counted),
		.error        (error),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.checked      (checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		result_ready <= calm || ($urandom_range(99) >= 31);
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || (psel && penable)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_request(action_t act, logic [SYM_W-1:0] sym, logic [NODE_W-1:0] node);
		while (!calm && $urandom_range(99) < 31) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		action     <= act;
		symbol     <= sym;
		node_index <= node;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		sent++;
		if (act == ACT_CLEAR) clears++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0 || !item_ready) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [2:0] v);
		drain();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {29'($urandom), v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic configure(logic [2:0] a, logic [2:0] d);
		write_reg(REG_ALPHABET, a);
		write_reg(REG_DEPTH, d);
		m_use = (a < 2) ? 2 : ((a > MAX_ALPHABET_DEF) ? MAX_ALPHABET_DEF : a);
		h_use = (d > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : d;
		settings++;
	endtask

	task automatic random_request();
		int unsigned       pick;
		int unsigned       span;
		logic [SYM_W-1:0]  sym;
		logic [NODE_W-1:0] node;
		pick = $urandom_range(999);
		span = (m_use ** (h_use + 1) - 1) / (m_use - 1);
		sym  = ($urandom_range(9) == 0) ? SYM_W'($urandom) : SYM_W'($urandom_range(m_use - 1));
		node = NODE_W'($urandom);
		if (pick < 6) begin
			send_request(ACT_CLEAR, sym, node);
		end else if (pick < 60) begin
			send_request(ACT_RESTART, sym, node);
		end else if (pick < 760) begin
			send_request(ACT_PUSH, sym, node);
		end else begin
			case ($urandom_range(9))
				0, 1: ;
				2, 3, 4: node = NODE_W'($urandom_range(span - 1));
				default: node = NODE_W'($urandom_range((span < 21) ? span - 1 : 20));
			endcase
			send_request(ACT_READ, sym, node);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fresh table, fill history, then count
		send_request(ACT_READ, 2'd0, '0);
		send_request(ACT_PUSH, 2'd3, '0);
		send_request(ACT_PUSH, 2'd0, '0);
		send_request(ACT_PUSH, 2'd1, '0);
		send_request(ACT_PUSH, 2'd2, '0);
		send_request(ACT_PUSH, 2'd3, '0);
		send_request(ACT_PUSH, 2'd1, '0);
		send_request(ACT_PUSH, 2'd2, '0);
		send_request(ACT_PUSH, 2'd0, '0);
		send_request(ACT_READ, 2'd2, '0);
		send_request(ACT_READ, 2'd3, NODE_W'(5460));
		send_request(ACT_READ, 2'd0, NODE_W'(5461));
		send_request(ACT_READ, 2'd3, '1);
		send_request(ACT_RESTART, 2'd0, '0);
		send_request(ACT_PUSH, 2'd1, '0);
		send_request(ACT_CLEAR, 2'd0, '0);
		send_request(ACT_READ, 2'd2, '0);

		// binary alphabet, root only: bad symbols and bad nodes
		configure(3'd2, 3'd0);
		send_request(ACT_PUSH, 2'd3, '0);
		send_request(ACT_PUSH, 2'd1, '0);
		send_request(ACT_READ, 2'd0, NODE_W'(1));
		send_request(ACT_READ, 2'd1, '0);
		send_request(ACT_READ, 2'd2, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			configure(alpha_plan[ph], depth_plan[ph]);
			calm <= (ph == 5);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_request();
		end

		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d requests including %0d table clears over %0d register settings",
			sent, clears, settings);
		$display("%0d results compared, %0d mismatches", checked, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
